// ===== sv/pfb_pkg.sv =====
package pfb_pkg;

    localparam int PanelWidth = 128;
    localparam int PanelPages = 8;
    localparam int ColW = 7;
    localparam int PageW = 3;
    localparam int AddrW = PageW + ColW;
    localparam int Depth = PanelWidth * PanelPages;
    localparam int ShiftColumns = 3;
    localparam int BarMargin = 2;
    localparam int FullPercent = 100;
    // divide by 100 as (p * 5243) >> 19, exact for p up to 251 * 100
    localparam int FillRecip = 5243;
    localparam int FillShift = 19;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_PIXEL = 3'd1,
        OP_LINE  = 3'd2,
        OP_BAR   = 3'd3,
        OP_SCAN  = 3'd4,
        OP_SHIFT = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_MUL,
        S_DIV,
        S_DRAW,
        S_RMW,
        S_SCAN_RD,
        S_SCAN_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic clr_start;  // start clear sweep
        logic clr_step;   // write zero, advance
        logic mul;        // form fill product
        logic div_step;   // fill divide by reciprocal multiply
        logic draw_start; // reset draw walker
        logic rd;         // read store at draw pixel
        logic wr;         // write back and advance walker
        logic scan_rd;    // read store at shifted scan position
        logic scan_adv;   // advance scan counters
        logic shift_step; // anti-burn step
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic draw_done;
        logic pix_ok;     // current walker pixel lies on the panel
    } t_stat;

endpackage

// ===== sv/pfb_if.sv =====
interface pfb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic signed [8:0] x;
    logic signed [7:0] y;
    logic signed [8:0] x_end;
    logic [7:0] width;
    logic [6:0] height;
    logic signed [7:0] percent;
    logic       pixel_on;
    modport source (output valid, operation, x, y, x_end, width, height, percent, pixel_on,
                    input ready);
    modport sink (input valid, operation, x, y, x_end, width, height, percent, pixel_on,
                  output ready);
endinterface

interface pfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [2:0] page;
    logic [6:0] column;
    logic       last_of_frame;
    modport source (output valid, data_byte, page, column, last_of_frame, input ready);
    modport sink (input valid, data_byte, page, column, last_of_frame, output ready);
endinterface

// ===== sv/pfb_ctrl.sv =====
module pfb_ctrl
    import pfb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  logic [2:0] i_op,
    output logic   o_ready,
    input  logic   i_out_busy,
    output t_cmd   o_cmd,
    input  t_stat  i_stat
);

    t_state r_state, n_state;

    // reset starts a clearing pass over the whole store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_op)
                        OP_CLEAR: begin
                            o_cmd.clr_start = 1'b1;
                            n_state = S_CLEAR;
                        end
                        OP_PIXEL, OP_LINE: begin
                            o_cmd.draw_start = 1'b1;
                            n_state = S_DRAW;
                        end
                        OP_BAR:   n_state = S_MUL;
                        OP_SCAN:  n_state = S_SCAN_RD;
                        OP_SHIFT: o_cmd.shift_step = 1'b1;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.draw_start = 1'b1;
                n_state = S_DRAW;
            end
            S_DRAW: begin
                if (i_stat.draw_done) begin
                    n_state = S_IDLE;
                end else if (i_stat.pix_ok) begin
                    o_cmd.rd = 1'b1;
                    n_state = S_RMW;
                end else begin
                    o_cmd.wr = 1'b1; // skip off-panel pixel
                end
            end
            S_RMW: begin
                o_cmd.wr = 1'b1;
                n_state = S_DRAW;
            end
            S_SCAN_RD: begin
                if (!i_out_busy) begin
                    o_cmd.scan_rd = 1'b1;
                    n_state = S_SCAN_OUT;
                end
            end
            S_SCAN_OUT: begin
                o_cmd.scan_adv = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== sv/pfb_dp.sv =====
module pfb_dp
    import pfb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    output t_stat  o_stat,
    input  logic [2:0] i_op,
    input  logic signed [8:0] i_x,
    input  logic signed [7:0] i_y,
    input  logic signed [8:0] i_x_end,
    input  logic [7:0] i_width,
    input  logic [6:0] i_height,
    input  logic signed [7:0] i_percent,
    input  logic   i_pixel_on,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output logic [7:0] o_data_byte,
    output logic [2:0] o_page,
    output logic [6:0] o_column,
    output logic   o_last_of_frame
);

    logic [7:0] r_mem [Depth];
    logic [7:0] r_rdata;

    logic [2:0] r_op;
    logic signed [10:0] r_x, r_y, r_xe;
    logic [7:0] r_w;
    logic [6:0] r_h;
    logic r_on;
    logic [6:0] r_pct;

    logic [AddrW-1:0] r_clr;
    logic [1:0] r_sh_col;
    logic       r_sh_page;
    logic [PageW-1:0] r_scan_page;
    logic [ColW-1:0]  r_scan_col;

    // fill: |width-4| * percent, then divide by 100 as a reciprocal multiply
    logic [14:0] r_prod;
    logic        r_neg;
    logic signed [9:0] r_fill;
    logic [27:0] w_recip;
    logic [8:0]  w_quo;

    // draw walker: phase 0 top/bottom rows, 1 side columns, 2 fill
    logic [1:0]  r_ph;
    logic signed [10:0] r_i, r_j;
    logic        r_sub;   // second pixel of a pair

    logic signed [10:0] w_s, h_s, w_px, w_py, w_hi;
    logic w_ok, w_done, w_skip;
    logic [AddrW-1:0] w_addr;
    logic [7:0] w_mask;
    logic signed [8:0] w_wm;
    logic [8:0] w_absw;

    // registered address of the pixel in read-modify-write
    logic r_ok_q;
    logic [AddrW-1:0] r_addr_q;
    logic [7:0] r_mask_q;
    logic r_on_eff;

    assign w_s = {3'b000, r_w};
    assign h_s = {4'b0000, r_h};
    assign w_hi = (r_xe > PanelWidth - 1) ? 11'(PanelWidth - 1) : r_xe;

    always_comb begin
        w_px = r_i;
        w_py = r_y;
        w_done = 1'b0;
        unique case (r_op)
            OP_PIXEL: begin
                w_px = r_x;
                w_done = r_sub;
            end
            OP_LINE: begin
                w_px = r_i;
                w_done = (r_i > w_hi);
            end
            default: begin
                unique case (r_ph)
                    2'd0: begin
                        w_px = r_x + r_i;
                        w_py = r_sub ? (r_y + h_s - 11'sd1) : r_y;
                    end
                    2'd1: begin
                        w_px = r_sub ? (r_x + w_s - 11'sd1) : r_x;
                        w_py = r_y + r_j;
                    end
                    2'd2: begin
                        w_px = r_x + 11'(BarMargin) + r_i;
                        w_py = r_y + r_j;
                    end
                    default: w_done = 1'b1;
                endcase
            end
        endcase
    end

    // bar walker steps that draw nothing: zero width or height, empty fill
    assign w_skip = (r_op == OP_BAR) &&
                    (((r_ph == 2'd0) && (r_w == 8'd0)) ||
                     ((r_ph == 2'd1) && (r_h == 7'd0)) ||
                     ((r_ph == 2'd2) && ((r_fill <= 0) || (r_i >= 11'(r_fill)) ||
                                         (r_j >= h_s - 11'(BarMargin)))));

    assign w_ok = (w_px >= 0) && (w_px < PanelWidth) && (w_py >= 0)
                  && (w_py < PanelPages * 8) && !w_done && !w_skip;
    assign w_addr = {w_py[PageW+2:3], w_px[ColW-1:0]};
    assign w_mask = 8'(1) << w_py[2:0];

    assign o_stat.clr_done  = (r_clr == AddrW'(Depth - 1));
    assign o_stat.draw_done = w_done;
    assign o_stat.pix_ok    = w_ok;

    assign w_wm = $signed({1'b0, r_w}) - 9'sd4;
    assign w_absw = w_wm[8] ? 9'(-w_wm) : 9'(w_wm);
    assign w_recip = r_prod * 13'(FillRecip);
    assign w_quo = w_recip[FillShift +: 9];

    // walker advance
    logic signed [10:0] n_i, n_j;
    logic [1:0] n_ph;
    logic n_sub;
    always_comb begin
        n_i = r_i; n_j = r_j; n_ph = r_ph; n_sub = r_sub;
        unique case (r_op)
            OP_PIXEL: n_sub = 1'b1;
            OP_LINE:  n_i = r_i + 11'sd1;
            default: begin
                unique case (r_ph)
                    2'd0: begin
                        n_sub = !r_sub;
                        if (r_sub) n_i = r_i + 11'sd1;
                        if (r_sub && (r_i + 11'sd1 >= w_s)) begin
                            n_ph = 2'd1; n_j = '0; n_sub = 1'b0;
                        end else if (r_w == 8'd0) begin
                            n_ph = 2'd1; n_j = '0; n_sub = 1'b0;
                        end
                    end
                    2'd1: begin
                        n_sub = !r_sub;
                        if (r_sub) n_j = r_j + 11'sd1;
                        if ((r_sub && (r_j + 11'sd1 >= h_s)) || r_h == 7'd0) begin
                            n_ph = 2'd2; n_i = '0; n_j = 11'(BarMargin); n_sub = 1'b0;
                        end
                    end
                    2'd2: begin
                        if (r_fill <= 0 || r_i >= 11'(r_fill)) begin
                            n_ph = 2'd3;
                        end else if (r_j + 11'sd1 >= h_s - 11'(BarMargin)) begin
                            n_j = 11'(BarMargin);
                            n_i = r_i + 11'sd1;
                            if (r_i + 11'sd1 >= 11'(r_fill)) n_ph = 2'd3;
                        end else begin
                            n_j = r_j + 11'sd1;
                        end
                        if (r_j >= h_s - 11'(BarMargin)) n_ph = 2'd3;
                    end
                    default: n_ph = 2'd3;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_x  <= 11'(i_x);
            r_y  <= 11'(i_y);
            r_xe <= 11'(i_x_end);
            r_w  <= i_width;
            r_h  <= i_height;
            r_on <= i_pixel_on;
            r_pct <= i_percent[7] ? 7'd0 :
                     (i_percent > 8'sd100) ? 7'(FullPercent) : i_percent[6:0];
        end
        if (i_cmd.mul) begin
            r_prod <= 15'(w_absw * r_pct);
            r_neg  <= w_wm[8];
        end
        if (i_cmd.div_step) begin
            r_fill <= r_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
        end
        if (i_cmd.draw_start) begin
            r_i <= (i_cmd.load && i_op == OP_LINE) ? ((i_x < 0) ? 11'sd0 : 11'(i_x)) : '0;
            r_j <= '0;
            r_ph <= 2'd0;
            r_sub <= 1'b0;
        end else if (i_cmd.wr) begin
            r_i <= n_i; r_j <= n_j; r_ph <= n_ph; r_sub <= n_sub;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[w_addr];
        end
        if (i_cmd.scan_rd) begin
            r_rdata <= r_mem[{r_scan_page - PageW'(r_sh_page),
                              r_scan_col - ColW'(r_sh_col)}];
        end
        if (i_cmd.clr_step) begin
            r_mem[r_clr] <= '0;
        end else if (i_cmd.wr && r_ok_q) begin
            r_mem[r_addr_q] <= (r_on_eff) ? (r_rdata | r_mask_q) : (r_rdata & ~r_mask_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok_q <= 1'b0;
        end else begin
            r_ok_q <= i_cmd.rd;
        end
        if (i_cmd.rd) begin
            r_addr_q <= w_addr;
            r_mask_q <= w_mask;
            r_on_eff <= (r_op == OP_BAR) ? 1'b1 : r_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_sh_col    <= '0;
            r_sh_page   <= 1'b0;
            r_scan_page <= '0;
            r_scan_col  <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_start) r_clr <= '0;
            else if (i_cmd.clr_step) r_clr <= r_clr + AddrW'(1);
            if (i_cmd.shift_step) begin
                if (r_sh_col == 2'(ShiftColumns - 1)) begin
                    r_sh_col  <= '0;
                    r_sh_page <= !r_sh_page;
                end else begin
                    r_sh_col <= r_sh_col + 2'd1;
                end
            end
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            if (i_cmd.scan_adv) begin
                o_out_valid <= 1'b1;
                o_data_byte <= r_rdata;
                o_page <= r_scan_page;
                o_column <= r_scan_col;
                o_last_of_frame <= (r_scan_page == PageW'(PanelPages - 1))
                                   && (r_scan_col == ColW'(PanelWidth - 1));
                r_scan_col <= r_scan_col + 1'b1;
                if (r_scan_col == ColW'(PanelWidth - 1)) r_scan_page <= r_scan_page + 1'b1;
            end
        end
    end

endmodule

// ===== sv/page_framebuffer_draw_and_shifted_scan_top.sv =====
// Monochrome page frame store, 8 pages x 128 columns, one byte = 8 rows.
// Input channel i_in carries one draw/scan item; output channel o_out
// carries one byte per scan tick item.
// Scan tick: S_SCAN_RD waits for a free output register and reads the store,
// then S_SCAN_OUT loads the byte into o_out; pixel and line take a read and a
// write back per on-panel pixel and skip each clipped position; bar forms the
// fill width (multiply, then reciprocal divide by 100), then walks outline and
// fill the same way, skipping steps that draw nothing; clear writes one store
// entry a cycle through the single RAM port; anti-burn step acts on accept.
// Throughput: one item at a time; the next item is taken once the
// current one has finished.
// Reset (synchronous, active low) clears the scan and shift counters and
// the output valid, then a clearing pass zeroes the whole store; the input
// is not ready until that pass ends.
// If the receiver stalls, the finished byte waits in the output register
// and further draw items still proceed; a second scan tick waits in the
// controller until the output register is free.
module page_framebuffer_draw_and_shifted_scan_top
    import pfb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pfb_in_if.sink    i_in,
    pfb_out_if.source o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    pfb_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_valid(i_in.valid), .i_op(i_in.operation), .o_ready(i_in.ready),
        .i_out_busy(o_out.valid && !o_out.ready),
        .o_cmd(w_cmd), .i_stat(w_stat)
    );

    pfb_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat),
        .i_op(i_in.operation), .i_x(i_in.x), .i_y(i_in.y), .i_x_end(i_in.x_end),
        .i_width(i_in.width), .i_height(i_in.height), .i_percent(i_in.percent),
        .i_pixel_on(i_in.pixel_on),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .o_data_byte(o_out.data_byte), .o_page(o_out.page),
        .o_column(o_out.column), .o_last_of_frame(o_out.last_of_frame)
    );

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_adv |-> !i_in.ready) else $error("ready during scan");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_rd |-> !(o_out.valid && !o_out.ready)) else $error("overrun");

endmodule

// ===== tb/sv/page_framebuffer_draw_and_shifted_scan_top_tb.sv =====
module page_framebuffer_draw_and_shifted_scan_top_tb;
    import pfb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam int RandItems = 630;
    localparam int CycleLimit = 3000000;
    localparam int DrainCycles = 2000;

    typedef struct {
        logic [2:0]        op;
        logic signed [8:0] x;
        logic signed [7:0] y;
        logic signed [8:0] x_end;
        logic [7:0]        width;
        logic [6:0]        height;
        logic signed [7:0] percent;
        logic              pixel_on;
    } draw_cmd_t;

    typedef struct {
        logic [7:0] data_byte;
        logic [2:0] page;
        logic [6:0] column;
        logic       last_of_frame;
    } scan_byte_t;

    typedef struct {
        draw_cmd_t  cmd;
        bit         known;
        scan_byte_t want;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    pfb_in_if  in_ch();
    pfb_out_if out_ch();

    page_framebuffer_draw_and_shifted_scan_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the panel
    logic [7:0] panel_mem [Depth];
    int unsigned shift_col_q, shift_pg_q, scan_pg_q, scan_col_q;
    scan_byte_t scan_bytes_q[$];
    scan_byte_t typed_q[$];
    bit         typed_valid_q[$];

    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;     // end part: no idling
    bit hold_rx = 1'b0;   // long receiver stall request

    function automatic void plot(int px, int py, bit on);
        int idx;
        if (px < 0 || px >= PanelWidth || py < 0 || py >= PanelPages * 8) return;
        idx = (py / 8) * PanelWidth + px;
        panel_mem[idx][py % 8] = on;
    endfunction

    function automatic void apply_cmd(draw_cmd_t c);
        int lo, hi, w, h, pct, fill;
        scan_byte_t sb;
        case (c.op)
            OP_CLEAR: foreach (panel_mem[i]) panel_mem[i] = '0;
            OP_PIXEL: plot(int'(c.x), int'(c.y), c.pixel_on);
            OP_LINE: begin
                lo = (c.x < 0) ? 0 : int'(c.x);
                hi = (c.x_end > PanelWidth - 1) ? PanelWidth - 1 : int'(c.x_end);
                for (int i = lo; i <= hi; i++) plot(i, int'(c.y), c.pixel_on);
            end
            OP_BAR: begin
                w = int'(c.width);
                h = int'(c.height);
                pct = int'(c.percent);
                if (pct < 0) pct = 0;
                if (pct > FullPercent) pct = FullPercent;
                for (int i = 0; i < w; i++) begin
                    plot(c.x + i, c.y, 1'b1);
                    plot(c.x + i, c.y + h - 1, 1'b1);
                end
                for (int j = 0; j < h; j++) begin
                    plot(c.x, c.y + j, 1'b1);
                    plot(c.x + w - 1, c.y + j, 1'b1);
                end
                fill = (w - 2 * BarMargin) * pct / FullPercent;
                for (int i = 0; i < fill; i++)
                    for (int j = BarMargin; j < h - BarMargin; j++)
                        plot(c.x + BarMargin + i, c.y + j, 1'b1);
            end
            OP_SCAN: begin
                sb.data_byte = panel_mem[((scan_pg_q + PanelPages - shift_pg_q) % PanelPages)
                    * PanelWidth + (scan_col_q + PanelWidth - shift_col_q) % PanelWidth];
                sb.page = scan_pg_q[2:0];
                sb.column = scan_col_q[6:0];
                sb.last_of_frame = (scan_pg_q == PanelPages - 1) &&
                                   (scan_col_q == PanelWidth - 1);
                scan_bytes_q.push_back(sb);
                scan_col_q++;
                if (scan_col_q >= PanelWidth) begin
                    scan_col_q = 0;
                    scan_pg_q = (scan_pg_q + 1) % PanelPages;
                end
            end
            OP_SHIFT: begin
                shift_col_q = (shift_col_q + 1) % ShiftColumns;
                if (shift_col_q == 0) shift_pg_q = (shift_pg_q + 1) % 2;
            end
            default: ;
        endcase
    endfunction

    task automatic report(string what, int want, int got);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %0d got %0d", what, want, got);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (in_ch.valid && in_ch.ready) begin
            draw_cmd_t c;
            c.op = in_ch.operation;
            c.x = in_ch.x;
            c.y = in_ch.y;
            c.x_end = in_ch.x_end;
            c.width = in_ch.width;
            c.height = in_ch.height;
            c.percent = in_ch.percent;
            c.pixel_on = in_ch.pixel_on;
            apply_cmd(c);
        end
        if (out_ch.valid && out_ch.ready) begin
            scan_byte_t w, t;
            if (scan_bytes_q.size() == 0) begin
                report("unexpected byte, column", -1, out_ch.column);
            end else begin
                w = scan_bytes_q.pop_front();
                if (typed_q.size() > 0) begin
                    t = typed_q.pop_front();
                    if (typed_valid_q.pop_front()) w = t;
                end
                if (out_ch.data_byte !== w.data_byte) report("data_byte", w.data_byte, out_ch.data_byte);
                if (out_ch.page !== w.page) report("page", w.page, out_ch.page);
                if (out_ch.column !== w.column) report("column", w.column, out_ch.column);
                if (out_ch.last_of_frame !== w.last_of_frame)
                    report("last_of_frame", w.last_of_frame, out_ch.last_of_frame);
            end
        end
        if (cycles >= CycleLimit) begin
            $display("timeout");
            $display("page_framebuffer_draw_and_shifted_scan_top regression: fail");
            $finish;
        end
    end

    // receiver
    initial begin
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
                out_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send(draw_cmd_t c);
        in_ch.valid <= 1'b1;
        in_ch.operation <= c.op;
        in_ch.x <= c.x;
        in_ch.y <= c.y;
        in_ch.x_end <= c.x_end;
        in_ch.width <= c.width;
        in_ch.height <= c.height;
        in_ch.percent <= c.percent;
        in_ch.pixel_on <= c.pixel_on;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    function automatic draw_cmd_t mk(logic [2:0] op, int x, int y, int xe, int w, int h,
                                     int pct, bit on);
        draw_cmd_t c;
        c.op = op;
        c.x = 9'(x);
        c.y = 8'(y);
        c.x_end = 9'(xe);
        c.width = 8'(w);
        c.height = 7'(h);
        c.percent = 8'(pct);
        c.pixel_on = on;
        return c;
    endfunction

    function automatic draw_cmd_t rand_cmd();
        draw_cmd_t c;
        int r;
        c.x = 9'($urandom);
        c.y = 8'($urandom);
        c.x_end = 9'($urandom);
        c.width = 8'($urandom);
        c.height = 7'($urandom);
        c.percent = 8'($urandom);
        c.pixel_on = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 45) c.op = OP_SCAN;
        else if (r < 63) c.op = OP_PIXEL;
        else if (r < 75) c.op = OP_LINE;
        else if (r < 85) c.op = OP_BAR;
        else if (r < 95) c.op = OP_SHIFT;
        else if (r < 97) c.op = OP_CLEAR;
        else c.op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
        // mostly on-panel coordinates so drawing lands in the scanned area
        if ($urandom_range(0, 3) != 0) begin
            c.x = 9'($urandom_range(0, PanelWidth - 1));
            c.y = 8'($urandom_range(0, PanelPages * 8 - 1));
            c.x_end = 9'(int'(c.x) + int'($urandom_range(0, 40)) - 5);
        end
        // keep bars small except now and then
        if (c.op == OP_BAR && $urandom_range(0, 29) != 0) begin
            c.width = 8'($urandom_range(0, 30));
            c.height = 7'($urandom_range(0, 20));
        end
        return c;
    endfunction

    stim_row_t rows[$];

    initial begin
        stim_row_t r;
        foreach (panel_mem[i]) panel_mem[i] = '0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_CLEAR;
        in_ch.x = '0;
        in_ch.y = '0;
        in_ch.x_end = '0;
        in_ch.width = '0;
        in_ch.height = '0;
        in_ch.percent = '0;
        in_ch.pixel_on = 1'b0;

        // directed table; known=1 rows carry a typed expectation
        r.known = 1'b1;
        r.want = '{8'd0, 3'd0, 7'd0, 1'b0};
        r.cmd = mk(OP_SCAN, 0, 0, 0, 0, 0, 0, 0);          rows.push_back(r);
        r.known = 1'b0;
        r.cmd = mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);         rows.push_back(r);
        r.cmd = mk(OP_PIXEL, 0, 0, 0, 0, 0, 0, 1);         rows.push_back(r);
        r.cmd = mk(OP_PIXEL, 127, 63, 0, 0, 0, 0, 1);      rows.push_back(r);
        r.cmd = mk(OP_PIXEL, -256, -128, 0, 0, 0, 0, 1);   rows.push_back(r);
        r.cmd = mk(OP_PIXEL, 255, 127, 0, 255, 127, 127, 1); rows.push_back(r);
        r.cmd = mk(OP_LINE, -256, 5, 255, 0, 0, 0, 1);     rows.push_back(r);
        r.cmd = mk(OP_LINE, 10, 5, 3, 0, 0, 0, 0);         rows.push_back(r);
        r.cmd = mk(OP_LINE, 20, 5, 30, 0, 0, 0, 0);        rows.push_back(r);
        r.cmd = mk(OP_BAR, 4, 20, 0, 20, 0, 50, 0);        rows.push_back(r);
        r.cmd = mk(OP_BAR, 30, 30, 0, 24, 10, -128, 0);    rows.push_back(r);
        r.cmd = mk(OP_BAR, 60, 40, 0, 30, 12, 127, 0);     rows.push_back(r);
        r.cmd = mk(OP_BAR, 100, 2, 0, 2, 3, 100, 0);       rows.push_back(r);
        r.cmd = mk(OP_SCAN, 0, 0, 0, 0, 0, 0, 0);          rows.push_back(r);
        r.cmd = mk(OP_SHIFT, 0, 0, 0, 0, 0, 0, 0);         rows.push_back(r);
        r.cmd = mk(OP_SPARE6, 0, 0, 0, 0, 0, 0, 1);        rows.push_back(r);
        r.cmd = mk(OP_SPARE7, 0, 0, 0, 0, 0, 0, 1);        rows.push_back(r);
        r.cmd = mk(OP_SCAN, 0, 0, 0, 0, 0, 0, 0);          rows.push_back(r);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].cmd.op == OP_SCAN) begin
                typed_q.push_back(rows[i].want);
                typed_valid_q.push_back(rows[i].known);
            end
            send(rows[i].cmd);
        end

        // walk most of a frame of scan ticks, with shifts mixed in
        for (int i = 0; i < Depth + 8; i++)
            send(($urandom_range(0, 31) == 0) ? mk(OP_SHIFT, 0, 0, 0, 0, 0, 0, 0)
                                             : mk(OP_SCAN, 0, 0, 0, 0, 0, 0, 0));

        for (int i = 0; i < RandItems; i++) begin
            if (i == RandItems / 3) begin
                // stall the receiver while scan items keep coming
                hold_rx = 1'b1;
                repeat (20) send(mk(OP_SCAN, 0, 0, 0, 0, 0, 0, 0));
            end
            if (i == RandItems / 2) begin
                in_ch.valid <= 1'b0;
                wait (scan_bytes_q.size() == 0);
                @(posedge i_clk);
            end
            if (i == RandItems - 200) quiet = 1'b1;
            send(rand_cmd());
        end
        in_ch.valid <= 1'b0;

        wait (scan_bytes_q.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (errors == 0 && scan_bytes_q.size() == 0)
            $display("page_framebuffer_draw_and_shifted_scan_top regression: pass");
        else
            $display("page_framebuffer_draw_and_shifted_scan_top regression: fail");
        $finish;
    end

endmodule

// ===== page_framebuffer_draw_and_shifted_scan_top.f =====
sv/pfb_pkg.sv
sv/pfb_if.sv
sv/pfb_ctrl.sv
sv/pfb_dp.sv
sv/page_framebuffer_draw_and_shifted_scan_top.sv
tb/sv/page_framebuffer_draw_and_shifted_scan_top_tb.sv
